// File: sv/spq_pkg.sv
// Shared types and codes of the sorted priority queue.
package spq_pkg;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam int VALUE_W = 32;
  localparam int PRIO_W  = 16;
  localparam int FILL_W  = 5;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic signed [PRIO_W-1:0]  prio;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;       // capture the new item, set hole to the tail
    logic       rd_head;    // read the front entry
    logic       rd_scan;    // read the entry just before the hole
    logic       shift_wr;   // move the read entry into the hole, step hole back
    logic       ins_wr;     // write the new item into the hole, count up
    logic       deq_pop;    // drop the front entry, count down
    logic       res_en;     // emit a result item
    logic       res_mem;    // result value comes from the read entry
    logic [1:0] res_status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic hole_zero;
    logic rd_gt;            // read entry priority above the new one
  } stat_t;

endpackage

// File: sv/spq_ctrl.sv
// Controller state machine of the sorted priority queue.
module spq_ctrl
  import spq_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  operation,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy
);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_ENQ_RD  = 2'd1;
  localparam logic [1:0] S_ENQ_CMP = 2'd2;
  localparam logic [1:0] S_DEQ_OUT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (operation == OP_ENQ) begin
            if (stat.full) begin
              cmd.res_en     = 1'b1;
              cmd.res_status = ST_FULL;
            end else begin
              state_next = S_ENQ_RD;
            end
          end else begin
            if (stat.empty) begin
              cmd.res_en     = 1'b1;
              cmd.res_status = ST_EMPTY;
            end else begin
              cmd.rd_head = 1'b1;
              state_next  = S_DEQ_OUT;
            end
          end
        end
      end
      S_ENQ_RD: begin
        if (stat.hole_zero) begin
          cmd.ins_wr     = 1'b1;
          cmd.res_en     = 1'b1;
          cmd.res_status = ST_OK;
          state_next     = S_IDLE;
        end else begin
          cmd.rd_scan = 1'b1;
          state_next  = S_ENQ_CMP;
        end
      end
      S_ENQ_CMP: begin
        if (stat.rd_gt) begin
          cmd.shift_wr = 1'b1;
          state_next   = S_ENQ_RD;
        end else begin
          cmd.ins_wr     = 1'b1;
          cmd.res_en     = 1'b1;
          cmd.res_status = ST_OK;
          state_next     = S_IDLE;
        end
      end
      S_DEQ_OUT: begin
        cmd.deq_pop    = 1'b1;
        cmd.res_en     = 1'b1;
        cmd.res_mem    = 1'b1;
        cmd.res_status = ST_OK;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// File: sv/spq_datapath.sv
// Entry memory, ring pointers and result register of the sorted priority queue.
module spq_datapath
  import spq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cmd_t                      cmd,
  input  logic signed [VALUE_W-1:0] value_in,
  input  logic signed [PRIO_W-1:0]  priority_in,
  output stat_t                     stat,
  output logic                      done,
  output logic signed [VALUE_W-1:0] value_out,
  output logic [1:0]                status,
  output logic [FILL_W-1:0]         fill_level
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_W = (AW+1)'(DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  entry_t mem [DEPTH];
  entry_t rd_entry;
  entry_t new_entry;

  logic [AW-1:0] head;
  logic [AW-1:0] hole;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic          we;
  logic          re;
  entry_t        wdata;
  logic [31:0]   fill_ext;

  // Ring address of a logical position counted from the head.
  function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] base,
                                              input logic [AW-1:0] offs);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, offs};
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[AW-1:0];
  endfunction

  assign re    = cmd.rd_head | cmd.rd_scan;
  assign raddr = cmd.rd_head ? head : ring_addr(head, hole - AW'(1));
  assign we    = cmd.shift_wr | cmd.ins_wr;
  assign waddr = ring_addr(head, hole);
  assign wdata = cmd.shift_wr ? rd_entry : new_entry;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_entry <= mem[raddr];
    end
  end

  always_comb begin
    count_next = count;
    if (cmd.ins_wr) begin
      count_next = count + CW'(1);
    end else if (cmd.deq_pop) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      head  <= '0;
    end else begin
      count <= count_next;
      if (cmd.deq_pop) begin
        head <= (head == LAST_A) ? '0 : head + AW'(1);
      end
    end
  end

  // Hole walks from the tail toward the front while larger entries move back.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      new_entry.value <= value_in;
      new_entry.prio  <= priority_in;
      hole            <= count[AW-1:0];
    end else if (cmd.shift_wr) begin
      hole <= hole - AW'(1);
    end
  end

  assign fill_ext = 32'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.res_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_en) begin
      value_out  <= cmd.res_mem ? rd_entry.value : '0;
      status     <= cmd.res_status;
      fill_level <= fill_ext[FILL_W-1:0];
    end
  end

  assign stat.empty     = (count == '0);
  assign stat.full      = (count >= DEPTH_C);
  assign stat.hole_zero = (hole == '0);
  assign stat.rd_gt     = (rd_entry.prio > new_entry.prio);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("entry count above depth");
  a_ins_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_wr |-> !stat.full)
    else $error("insert into a full store");
  a_shift_hole: assert property (@(posedge clk) disable iff (rst)
    cmd.shift_wr |-> !stat.hole_zero && $past(cmd.rd_scan))
    else $error("shift without a preceding scan read");
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    cmd.deq_pop |=> count == $past(count) - CW'(1))
    else $error("dequeue did not lower the count");
`endif

endmodule

// File: sv/sorted_priority_queue.sv
// Top level of the sorted priority queue: controller plus datapath.
//
// Holds up to DEPTH entries (a signed 32-bit value and a signed 16-bit
// priority) in ascending priority order; a smaller number is served first and
// equal priorities leave first-in, first-out. Raise start with operation,
// value_in and priority_in while busy is low; the item is taken at that edge.
// Each item yields exactly one result, shown on value_out, status and
// fill_level for a single cycle while done is high. The receiver cannot stall
// it, so sample it on that cycle. A dequeue keeps busy high while it reads
// the front entry, and its result follows right after; a dequeue on an empty
// queue or an enqueue into a full one never raises busy and reports on the
// next cycle. An enqueue keeps busy high while it moves the stored entries of
// larger priority back one by one, and skips the last compare when it lands at
// the front, with the result on the cycle after busy falls. The insertion walk
// runs over the entry memory, one read and one write port, where each entry
// moved takes a read state and then a compare-and-write state. Entries live in
// a ring buffer, so a dequeue only advances the head pointer and lowers the
// count. The memory is not cleared at reset; only stored entries are ever read.
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      operation,
  input  logic signed [VALUE_W-1:0] value_in,
  input  logic signed [PRIO_W-1:0]  priority_in,
  output logic                      done,
  output logic signed [VALUE_W-1:0] value_out,
  output logic [1:0]                status,
  output logic [FILL_W-1:0]         fill_level
);

  cmd_t  cmd;
  stat_t stat;

  // Sequence each item: decide on full or empty, walk the hole, emit result.
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  // Hold the entries, pointers and the result register.
  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .value_in    (value_in),
    .priority_in (priority_in),
    .stat        (stat),
    .done        (done),
    .value_out   (value_out),
    .status      (status),
    .fill_level  (fill_level)
  );

endmodule

// File: verif/spq_checker.sv
// Result checker for the sorted priority queue: predicts each result and compares it.
module spq_checker
  import spq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  logic                      operation,
  input  logic signed [VALUE_W-1:0] value_in,
  input  logic signed [PRIO_W-1:0]  priority_in,
  input  logic                      done,
  input  logic signed [VALUE_W-1:0] value_out,
  input  logic [1:0]                status,
  input  logic [FILL_W-1:0]         fill_level,
  output int                        fail_count,
  output int                        pending
);

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [1:0]                status;
    logic [FILL_W-1:0]         fill;
  } result_t;

  // Shadow copy of the stored entries, front first, in serving order.
  entry_t  ladder [DEPTH];
  int      stored = 0;
  int      errors = 0;
  result_t due_results [$];

  assign fail_count = errors;

  // Apply one item to the shadow queue and return the result it must cause.
  function automatic result_t apply_queue_op(input logic op,
                                             input logic signed [VALUE_W-1:0] val,
                                             input logic signed [PRIO_W-1:0] prio);
    result_t res;
    int      pos;
    res.value  = '0;
    res.status = ST_OK;
    if (op == OP_ENQ) begin
      if (stored >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        // Land behind every entry of equal or smaller priority.
        pos = 0;
        while (pos < stored && ladder[pos].prio <= prio) pos++;
        for (int i = stored; i > pos; i--) ladder[i] = ladder[i-1];
        ladder[pos].value = val;
        ladder[pos].prio  = prio;
        stored++;
      end
    end else begin
      if (stored == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.value = ladder[0].value;
        for (int i = 1; i < stored; i++) ladder[i-1] = ladder[i];
        stored--;
      end
    end
    res.fill = FILL_W'(stored);
    return res;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      stored = 0;
      due_results.delete();
    end else begin
      // Results never share an edge with the acceptance of their own item.
      if (done) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result value_out %0d status %0d fill_level %0d",
                   $time, value_out, status, fill_level);
          errors++;
        end else begin
          want = due_results.pop_front();
          if (value_out !== want.value) begin
            $display("%0t: value_out expected %0d, got %0d", $time, want.value, value_out);
            errors++;
          end
          if (status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, status);
            errors++;
          end
          if (fill_level !== want.fill) begin
            $display("%0t: fill_level expected %0d, got %0d", $time, want.fill, fill_level);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        due_results.push_back(apply_queue_op(operation, value_in, priority_in));
      end
    end
    pending <= due_results.size();
  end

endmodule

// File: verif/tb_top.sv
// Testbench top for the sorted priority queue: clock, reset, stimulus and verdict.
module tb_top;
  import spq_pkg::*;

  localparam int DEPTH         = 16;
  localparam int RANDOM_ITEMS  = 1200;
  localparam int CALM_TAIL     = 100;   // last items go back to back
  localparam int STALL_LIMIT   = 1000;  // cycles with no item or result moving
  localparam int SETTLE_CYCLES = 40;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic                      operation;
  logic signed [VALUE_W-1:0] value_in;
  logic signed [PRIO_W-1:0]  priority_in;
  logic                      done;
  logic signed [VALUE_W-1:0] value_out;
  logic [1:0]                status;
  logic [FILL_W-1:0]         fill_level;

  int fail_count;
  int pending;
  int stall_cycles = 0;
  bit idle_on = 1'b1;

  sorted_priority_queue #(.DEPTH(DEPTH)) dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .value_in    (value_in),
    .priority_in (priority_in),
    .done        (done),
    .value_out   (value_out),
    .status      (status),
    .fill_level  (fill_level)
  );

  spq_checker #(.DEPTH(DEPTH)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .value_in    (value_in),
    .priority_in (priority_in),
    .done        (done),
    .value_out   (value_out),
    .status      (status),
    .fill_level  (fill_level),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  // Period of 10: low half first, so the first rising edge comes at 5.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: count cycles in which neither an item nor a result moves.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer one item and hold it until the queue takes it. Call at a rising edge;
  // returns at the edge that accepted the item, with start still high.
  task automatic push_item(input logic op,
                           input logic signed [VALUE_W-1:0] val,
                           input logic signed [PRIO_W-1:0] prio);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      // Idle burst: lands while the queue may still be busy with the last item.
      gap = $urandom_range(1, 10);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    operation   <= op;
    value_in    <= val;
    priority_in <= prio;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and wait until every predicted result has come back.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    logic                      op;
    logic signed [VALUE_W-1:0] val;
    logic signed [PRIO_W-1:0]  prio;
    int                        enq_pct;

    rst         <= 1'b1;
    start       <= 1'b0;
    operation   <= OP_ENQ;
    value_in    <= '0;
    priority_in <= '0;
    enq_pct     = 50;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Dequeue on an empty queue, with every ignored bit set.
    push_item(OP_DEQ, '1, '1);
    // Extreme values, extreme priorities, and ties that must leave in order.
    push_item(OP_ENQ, 32'sh7FFF_FFFF, 16'sd0);
    push_item(OP_ENQ, 32'sh8000_0000, 16'sd0);
    push_item(OP_ENQ, -32'sd1, 16'sh7FFF);
    push_item(OP_ENQ, 32'sd0, 16'sh7FFF);
    push_item(OP_ENQ, 32'sd1, -16'sd1);
    push_item(OP_ENQ, 32'sd2, 16'sd1);
    push_item(OP_ENQ, 32'sd3, -16'sd32767);
    for (int k = 0; k < 8; k++) begin
      push_item(OP_ENQ, 32'(k * 1000 + 7), PRIO_W'(k % 4) - 16'sd2);
    end
    // Sixteenth entry lands at the front and moves every stored entry back.
    push_item(OP_ENQ, 32'sh5555_5555, 16'sh8000);
    // Enqueue into a full queue: dropped and flagged.
    push_item(OP_ENQ, 32'shAAAA_AAAA, 16'sh8000);
    repeat (4) push_item(OP_DEQ, '0, '0);

    // Random part: phases lean toward filling or draining, or hold even, so that
    // the queue hits both full and empty often; priorities mostly crowd a narrow
    // band to force ties.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) begin
        case ($urandom_range(0, 2))
          0:       enq_pct = 15;
          1:       enq_pct = 50;
          default: enq_pct = 85;
        endcase
      end
      if (n % 100 == 0) idle_on = ($urandom_range(0, 2) != 0);
      if (n >= RANDOM_ITEMS - CALM_TAIL) idle_on = 1'b0;
      // Hold off once until the queue has answered everything.
      if (n == RANDOM_ITEMS / 2) drain_results();
      op   = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
      val  = $urandom();
      prio = PRIO_W'($urandom());
      if ($urandom_range(0, 9) < 7) prio = PRIO_W'($urandom_range(0, 6) - 3);
      push_item(op, val, prio);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
